// ===== hw/rtl/kvf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_pkg
// Shared constants and types of the versioned key-value floor lookup core.
// ----------------------------------------------------------------------------
package kvf_pkg;

   localparam int KEY_SLOTS     = 16;
   localparam int HISTORY_DEPTH = 64;
   localparam int KEY_BITS      = 32;
   localparam int VALUE_BITS    = 32;
   localparam int TIME_BITS     = 31;
   localparam int STATUS_BITS   = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int MEM_DEPTH = KEY_SLOTS * HISTORY_DEPTH;
   localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 40;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_STORED     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_FOUND      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_HIST_FULL  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_TIME_BAD   = 3'd5;

   typedef struct packed {
      logic                  is_get;
      logic                  hit;
      logic                  table_full;
      logic [SLOT_W-1:0]     slot;
      logic [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]  stamp;
   } job_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  stamp;
      logic [VALUE_BITS-1:0] value;
   } hist_entry_type;

   localparam int HIST_W = $bits(hist_entry_type);

endpackage
`default_nettype wire

// ===== hw/rtl/kvf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module kvf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/kvf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_front
// Accepts requests, matches the key against the tag table, allocates slots.
// ----------------------------------------------------------------------------
module kvf_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_opcode,
   input  wire logic [kvf_pkg::KEY_BITS-1:0] req_key,
   input  wire logic [kvf_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic [kvf_pkg::TIME_BITS-1:0]  req_stamp,
   input  wire logic                         push_ready,
   output logic                              push_valid,
   output kvf_pkg::job_type                  push_job
);
   import kvf_pkg::*;

   logic [KEY_BITS-1:0] slot_tags_ff [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] slot_valid_ff;
   logic                match;
   logic [SLOT_W-1:0]   match_slot;
   logic                free;
   logic [SLOT_W-1:0]   free_slot;
   logic                accept;

   always_comb begin
      match      = 1'b0;
      match_slot = '0;
      free       = 1'b0;
      free_slot  = '0;
      for (int s = KEY_SLOTS - 1; s >= 0; s--) begin
         if (slot_valid_ff[s] && slot_tags_ff[s] == req_key) begin
            match      = 1'b1;
            match_slot = SLOT_W'(s);
         end
         if (!slot_valid_ff[s]) begin
            free      = 1'b1;
            free_slot = SLOT_W'(s);
         end
      end
   end

   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_job.is_get     = (req_opcode == OP_GET);
      push_job.hit        = match || (req_opcode == OP_SET && free);
      push_job.table_full = !match && !free;
      push_job.slot       = match ? match_slot : free_slot;
      push_job.value      = req_value;
      push_job.stamp      = req_stamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (accept && req_opcode == OP_SET && !match && free) begin
         slot_valid_ff[free_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_SET && !match && free) begin
         slot_tags_ff[free_slot] <= req_key;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/kvf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_queue
// Short FIFO of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
module kvf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire kvf_pkg::job_type push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output kvf_pkg::job_type      pop_job,
   input  wire logic             pop_ready
);
   import kvf_pkg::*;

   job_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/kvf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_back
// Executes jobs: appends history entries and binary-searches for a floor.
// ----------------------------------------------------------------------------
module kvf_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            pop_valid,
   input  wire kvf_pkg::job_type                pop_job,
   output logic                                 pop_ready,
   output logic                                 rsp_valid,
   output logic [kvf_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [kvf_pkg::VALUE_BITS-1:0]       rsp_value,
   input  wire logic                            rsp_ready
);
   import kvf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LAST_CHK, S_PROBE, S_PROBE_CHK, S_FETCH_CHK, S_DONE
   } state_type;

   state_type              state_ff;
   job_type                job_ff;
   logic [CNT_W-1:0]       counts_ff [KEY_SLOTS];
   logic [CNT_W-1:0]       lo_ff;
   logic [CNT_W-1:0]       hi_ff;
   logic [CNT_W-1:0]       mid_ff;
   logic [STATUS_BITS-1:0] res_status_ff;
   logic [VALUE_BITS-1:0]  res_value_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;

   logic [CNT_W-1:0]       pop_cnt;
   logic [CNT_W-1:0]       mid_in;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   hist_entry_type         wr_data;
   hist_entry_type         rd_data;
   logic [SLOT_W-1:0]      cur_slot;
   logic [CNT_W-1:0]       cur_idx;

   function automatic logic [ADDR_W-1:0] hist_addr(logic [SLOT_W-1:0] slot,
                                                   logic [CNT_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(slot) * ADDR_W'(HISTORY_DEPTH));
      return base + ADDR_W'(idx[IDX_W-1:0]);
   endfunction

   assign pop_cnt   = counts_ff[pop_job.slot];
   assign mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pop_ready = (state_ff == S_IDLE);

   always_comb begin
      rd_en    = 1'b0;
      cur_slot = job_ff.slot;
      cur_idx  = '0;
      wr_en    = 1'b0;
      wr_data.stamp = job_ff.stamp;
      wr_data.value = job_ff.value;
      wr_addr  = hist_addr(job_ff.slot, counts_ff[job_ff.slot]);
      unique case (state_ff)
         S_IDLE: begin
            cur_slot = pop_job.slot;
            cur_idx  = pop_cnt - 1'b1;
            if (pop_valid && !pop_job.is_get && pop_job.hit) begin
               if (pop_cnt == '0) begin
                  wr_en         = 1'b1;
                  wr_data.stamp = pop_job.stamp;
                  wr_data.value = pop_job.value;
                  wr_addr       = hist_addr(pop_job.slot, '0);
               end else if (pop_cnt != CNT_W'(HISTORY_DEPTH)) begin
                  rd_en = 1'b1;
               end
            end
         end
         S_LAST_CHK: begin
            wr_en = (job_ff.stamp > rd_data.stamp);
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_en   = 1'b1;
               cur_idx = mid_in;
            end else if (lo_ff != '0) begin
               rd_en   = 1'b1;
               cur_idx = lo_ff - 1'b1;
            end
         end
         S_PROBE_CHK, S_FETCH_CHK, S_DONE: begin
         end
         default: begin
         end
      endcase
      rd_addr = hist_addr(cur_slot, cur_idx);
   end

   kvf_ram #(
      .WIDTH (HIST_W),
      .DEPTH (MEM_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < KEY_SLOTS; s++) begin
            counts_ff[s] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  job_ff       <= pop_job;
                  lo_ff        <= '0;
                  hi_ff        <= pop_cnt;
                  res_value_ff <= '0;
                  state_ff     <= S_DONE;
                  if (pop_job.is_get) begin
                     res_status_ff <= ST_NOT_FOUND;
                     if (pop_job.hit) begin
                        state_ff <= S_PROBE;
                     end
                  end else if (pop_job.table_full) begin
                     res_status_ff <= ST_TABLE_FULL;
                  end else if (pop_cnt == CNT_W'(HISTORY_DEPTH)) begin
                     res_status_ff <= ST_HIST_FULL;
                  end else if (pop_cnt == '0) begin
                     res_status_ff           <= ST_STORED;
                     counts_ff[pop_job.slot] <= CNT_W'(1);
                  end else begin
                     state_ff <= S_LAST_CHK;
                  end
               end
            end
            S_LAST_CHK: begin
               state_ff <= S_DONE;
               if (job_ff.stamp > rd_data.stamp) begin
                  res_status_ff          <= ST_STORED;
                  counts_ff[job_ff.slot] <= counts_ff[job_ff.slot] + 1'b1;
               end else begin
                  res_status_ff <= ST_TIME_BAD;
               end
            end
            S_PROBE: begin
               mid_ff <= mid_in;
               if (lo_ff < hi_ff) begin
                  state_ff <= S_PROBE_CHK;
               end else if (lo_ff != '0) begin
                  state_ff <= S_FETCH_CHK;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_PROBE_CHK: begin
               if (rd_data.stamp <= job_ff.stamp) begin
                  lo_ff <= mid_ff + 1'b1;
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= S_PROBE;
            end
            S_FETCH_CHK: begin
               res_status_ff <= ST_FOUND;
               res_value_ff  <= rd_data.value;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

`ifndef SYNTHESIS
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_PROBE_CHK) |-> (lo_ff <= hi_ff))
      else $error("search window inverted");
   a_hi_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (hi_ff <= CNT_W'(HISTORY_DEPTH)))
      else $error("search bound beyond history depth");
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FOUND) |-> (rsp_value_ff == '0))
      else $error("nonzero value without a hit");
   a_fetch_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH_CHK) |-> (lo_ff != '0))
      else $error("fetch with empty floor");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/versioned_key_value_floor_lookup_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// versioned_key_value_floor_lookup_core
// Versioned key-value table: set appends a timestamped value, get returns the
// latest value at or below the query time.
//
//   Channel  Direction  Contents
//   req_*    in         tuser: opcode; tdata: key, value, timestamp
//   rsp_*    out        tdata: status, result value
//
// In the back end a get is a binary search with one history memory read per
// probe plus one fetch.
// The front and back end are coupled by a two-entry job queue.
// Reset is synchronous and clears the tag valid bits, counts and queue.
// A stalled response holds the back end only; the front keeps queuing until the job queue is full.
// ----------------------------------------------------------------------------
module versioned_key_value_floor_lookup_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: key_tag[31:0], value_word[63:32], time_stamp[94:64], zero pad[95]
   input  wire logic [kvf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: opcode
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: status[2:0], result_value[34:3], zero pad[39:35]
   output logic [kvf_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import kvf_pkg::*;

   logic                   push_valid;
   logic                   push_ready;
   job_type                push_job;
   logic                   pop_valid;
   logic                   pop_ready;
   job_type                pop_job;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [VALUE_BITS-1:0]  rsp_value;

   kvf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .req_value  (req_tdata[32 +: VALUE_BITS]),
      .req_stamp  (req_tdata[64 +: TIME_BITS]),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   kvf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   kvf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_ready  (rsp_tready)
   );

   assign req_tready = push_ready;
   assign rsp_tdata  = {(RSP_DATA_W - STATUS_BITS - VALUE_BITS)'(0), rsp_value, rsp_status};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the versioned key-value floor lookup core. Sets and
// gets are streamed in under random idling on both channels; a behavioral
// copy of the key table and histories predicts each response in order.
// ----------------------------------------------------------------------------
module tb_top;
   import kvf_pkg::*;

   typedef struct packed {
      logic                  op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [TIME_BITS-1:0]  stamp;
   } request_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  value;
      logic [STATUS_BITS-1:0] status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int          send_idle_pct = 31;
   int          take_idle_pct = 55;
   int          error_count = 0;

   logic [KEY_BITS-1:0]   tag_of[KEY_SLOTS];
   logic                  used[KEY_SLOTS];
   int                    count_of[KEY_SLOTS];
   logic [VALUE_BITS-1:0] hist_value[KEY_SLOTS][HISTORY_DEPTH];
   logic [TIME_BITS-1:0]  hist_stamp[KEY_SLOTS][HISTORY_DEPTH];
   logic [KEY_BITS-1:0]   key_pool[24];
   logic [TIME_BITS-1:0]  last_stamp[24];

   versioned_key_value_floor_lookup_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic answer_type lookup_table(request_type r);
      answer_type a;
      int slot;
      int lo;
      int hi;
      int mid;
      a = '{status: ST_NOT_FOUND, value: '0};
      slot = -1;
      for (int s = 0; s < KEY_SLOTS; s++)
         if (slot < 0 && used[s] && tag_of[s] == r.key) slot = s;
      if (r.op == OP_SET) begin
         if (slot < 0)
            for (int s = 0; s < KEY_SLOTS; s++)
               if (slot < 0 && !used[s]) begin
                  slot = s;
                  used[s] = 1'b1;
                  tag_of[s] = r.key;
                  count_of[s] = 0;
               end
         if (slot < 0) a.status = ST_TABLE_FULL;
         else if (count_of[slot] >= HISTORY_DEPTH) a.status = ST_HIST_FULL;
         else if (count_of[slot] > 0 && r.stamp <= hist_stamp[slot][count_of[slot]-1])
            a.status = ST_TIME_BAD;
         else begin
            hist_value[slot][count_of[slot]] = r.value;
            hist_stamp[slot][count_of[slot]] = r.stamp;
            count_of[slot]++;
            a.status = ST_STORED;
         end
      end else if (slot >= 0) begin
         lo = 0;
         hi = count_of[slot];
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (hist_stamp[slot][mid] <= r.stamp) lo = mid + 1;
            else hi = mid;
         end
         if (lo > 0) begin
            a.status = ST_FOUND;
            a.value = hist_value[slot][lo-1];
         end
      end
      return a;
   endfunction

   function automatic request_type make_request(logic op, logic [KEY_BITS-1:0] key,
                                                logic [VALUE_BITS-1:0] value,
                                                logic [TIME_BITS-1:0] stamp);
      request_type r;
      r.op = op;
      r.key = key;
      r.value = value;
      r.stamp = stamp;
      return r;
   endfunction

   task automatic queue_request(request_type r);
      pending_requests = {pending_requests, r};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_answers = {expected_answers, lookup_table(r)};
            req_tvalid <= 1'b1;
            req_tuser <= r.op;
            req_tdata <= {1'b0, r.stamp, r.value, r.key};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_type want;
         answer_type got;
         got = rsp_tdata[STATUS_BITS+VALUE_BITS-1:0];
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               error_count++;
            end
            if (got.value !== want.value) begin
               $display("%0t: value expected %h actual %h", $time, want.value, got.value);
               error_count++;
            end
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= take_idle_pct);
   end

   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      logic op;
      for (int s = 0; s < KEY_SLOTS; s++) begin
         used[s] = 1'b0;
         count_of[s] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, misses, bad stamps, full history, full table.
      queue_request(make_request(OP_GET, 32'hFFFF_FFFF, '1, '1));
      queue_request(make_request(OP_SET, 32'hFFFF_FFFF, '1, 31'd10));
      queue_request(make_request(OP_GET, 32'hFFFF_FFFF, '0, 31'd9));
      queue_request(make_request(OP_GET, 32'hFFFF_FFFF, '0, 31'd10));
      queue_request(make_request(OP_SET, 32'hFFFF_FFFF, '0, 31'd10));
      queue_request(make_request(OP_SET, 32'hFFFF_FFFF, '0, 31'd5));
      queue_request(make_request(OP_SET, 32'h0, 32'h0, 31'd0));
      queue_request(make_request(OP_SET, 32'h0, 32'hA5A5_5A5A, '1));
      queue_request(make_request(OP_GET, 32'h0, '1, '1));
      queue_request(make_request(OP_GET, 32'h0, '0, 31'd0));
      for (int i = 0; i < HISTORY_DEPTH + 1; i++)
         queue_request(make_request(OP_SET, 32'h1234, $urandom, 31'(100 + i)));
      queue_request(make_request(OP_GET, 32'h1234, '0, 31'd131));
      for (int i = 0; i < KEY_SLOTS; i++)
         queue_request(make_request(OP_SET, 32'(1000 + i), $urandom, 31'd1));
      queue_request(make_request(OP_GET, 32'd1005, '0, 31'd1));
      drain();

      // Random: new key pool per phase, mostly gets, sets mostly with rising stamps.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
         take_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
         if (phase > 0) begin
            // Fresh keys cannot fit, so exercise the full-table path too.
            for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
         end else begin
            for (int i = 0; i < 24; i++) key_pool[i] = 32'(1000 + i);
         end
         for (int i = 0; i < 24; i++) last_stamp[i] = 31'($urandom_range(50));
         for (int i = 0; i < 285; i++) begin
            k = (i % 7 == 0) ? $urandom_range(23) : $urandom_range(15);
            op = ($urandom_range(99) < 55) ? OP_GET : OP_SET;
            if (op == OP_SET) begin
               if ($urandom_range(9) == 0) begin
                  queue_request(make_request(op, key_pool[k], $urandom,
                                             31'($urandom_range(last_stamp[k]))));
               end else begin
                  last_stamp[k] = last_stamp[k] + 31'($urandom_range(1, 40));
                  if ($urandom_range(40) == 0) last_stamp[k] = 31'(31'h7FFF_FF00 | $urandom);
                  queue_request(make_request(op, key_pool[k], $urandom, last_stamp[k]));
               end
            end else begin
               queue_request(make_request(op,
                  ($urandom_range(19) == 0) ? $urandom : key_pool[k], $urandom,
                  ($urandom_range(19) == 0) ? 31'($urandom)
                                            : 31'($urandom_range(last_stamp[k] + 20))));
            end
         end
         drain();
      end
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
